@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAMES     = 65536;
  localparam int WORD_BITS  = 32;
  localparam int FRAME_SIZE = 4096;

  localparam int ADDR_W      = 32;
  localparam int KB_W        = 22;
  localparam int KB_SHIFT    = 10;
  localparam int MB_W        = KB_W + KB_SHIFT;
  localparam int WORDS       = FRAMES / WORD_BITS;
  localparam int WORD_SHIFT  = $clog2(WORD_BITS);
  localparam int FRAME_SHIFT = $clog2(FRAME_SIZE);
  localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;
  localparam int IDX_W       = $clog2(FRAMES);
  localparam int WORD_IDX_W  = $clog2(WORDS);
  localparam int WCOUNT_W    = WORD_IDX_W + 1;
  localparam int COUNT_W     = IDX_W + 1;
  localparam int RES_W       = FRAME_W + 1;
  localparam int CMP_W       = (RES_W > COUNT_W) ? RES_W : COUNT_W;
  localparam int BIT_W       = WORD_SHIFT;
  localparam int CFG_IDX_W   = 2;

  localparam logic [KB_W-1:0] KB_RESET = KB_W'(262144);

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_ALLOC_BIT,
    ST_ALLOC_SET,
    ST_FREE_RD,
    ST_FREE_CHK
  } state_t;

endpackage

@@ rtl/bitmap_frame_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit physical frame allocator with one used bit per frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries op and free_address; one result
// (frame_address, status, used_frames) leaves on the output channel
// (out_valid/out_stall) for every input transfer. The config channel
// (cfg_valid/cfg_ready, always ready) writes the memory size in KiB (index 0)
// and kernel_end_address (index 1); the user must see that it is written only
// while the block is idle, as the block itself has no check for it. One item
// is worked at a time, all through the single bitmap memory port; in_stall is
// high from transfer until its result has entered the output register:
//   init : one word written per cycle, for every managed word
//   alloc: take the item, read and check each word scanned, binary search for
//          the lowest clear bit, then set the bit and hand over the result
//   free : range check, read, update
// A finished result sits in the output register; while the receiver stalls
// it holds, and the next item is taken but its result waits.
// Reset clears the managed word count and the used count, so nothing is
// managed until an init; bitmap words are always written by init before
// they are read, so the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [bfa_pkg::ADDR_W-1:0]        free_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bfa_pkg::ADDR_W-1:0]        frame_address,
  output logic [1:0]                        status,
  output logic [bfa_pkg::COUNT_W-1:0]       used_frames,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfa_pkg::ADDR_W-1:0]        cfg_data
);
  import bfa_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES = '1;
  localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);

  state_t                 state, state_next;
  logic [KB_W-1:0]        mem_size_kib;
  logic [ADDR_W-1:0]      kernel_end_address;
  logic [WCOUNT_W-1:0]    active_words, active_words_next;
  logic [RES_W-1:0]       reserved, reserved_next;
  logic [COUNT_W-1:0]     used_count, used_count_next;
  logic [WCOUNT_W-1:0]    wc, wc_next;
  logic [IDX_W-1:0]       fidx, fidx_next;
  logic [WORD_BITS-1:0]   word, word_next;
  logic [WORD_BITS-1:0]   srch, srch_next;
  logic [BIT_W-1:0]       bitidx, bitidx_next;
  logic [BIT_W-1:0]       half, half_next;
  logic [ADDR_W-1:0]      res_addr, res_addr_next;
  logic [1:0]             res_status, res_status_next;
  logic                   res_pending, res_pending_next;

  logic [WORD_BITS-1:0]   mem [WORDS];
  logic [WORD_BITS-1:0]   mem_q;
  logic [WORD_IDX_W-1:0]  mem_ra, mem_wa;
  logic [WORD_BITS-1:0]   mem_wd;
  logic                   mem_we;

  logic [MB_W-1:0]        frames_raw, frames_sat;
  logic [WCOUNT_W-1:0]    init_words;
  logic [RES_W-1:0]       init_reserved;
  logic [COUNT_W-1:0]     init_count;
  logic [FRAME_W-1:0]     free_frame;
  logic [COUNT_W-1:0]     limit;
  logic                   free_out_range;
  logic [IDX_W-1:0]       first;
  logic [CMP_W-1:0]       res_c, first_c;
  logic [WORD_BITS-1:0]   init_val;
  logic [WORD_BITS-1:0]   lo_mask;
  logic [WCOUNT_W-1:0]    wc_inc;
  logic                   out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || res_pending;
  assign out_free  = !out_valid || !out_stall;

  // init values from config
  assign frames_raw    = {mem_size_kib, {KB_SHIFT{1'b0}}} >> FRAME_SHIFT;
  assign frames_sat    = (frames_raw > MB_W'(FRAMES)) ? MB_W'(FRAMES) : frames_raw;
  assign init_words    = WCOUNT_W'(frames_sat >> WORD_SHIFT);
  assign init_reserved = RES_W'(kernel_end_address[ADDR_W-1:FRAME_SHIFT]) + RES_W'(1);
  assign init_count    = (CMP_W'(init_reserved) > CMP_W'(FRAMES)) ?
                         COUNT_W'(FRAMES) : COUNT_W'(init_reserved);

  // free range check
  assign free_frame     = free_address[ADDR_W-1:FRAME_SHIFT];
  assign limit          = {active_words, {WORD_SHIFT{1'b0}}};
  assign free_out_range = CMP_W'(free_frame) >= CMP_W'(limit);

  // init word pattern
  assign first   = {wc[WORD_IDX_W-1:0], {WORD_SHIFT{1'b0}}};
  assign res_c   = CMP_W'(reserved);
  assign first_c = CMP_W'(first);
  always_comb begin
    if (res_c <= first_c) begin
      init_val = '0;
    end else if (res_c >= first_c + CMP_W'(WORD_BITS)) begin
      init_val = ONES;
    end else begin
      init_val = ~(ONES << reserved[WORD_SHIFT-1:0]);
    end
  end

  assign lo_mask = ~(ONES << half);
  assign wc_inc  = wc + WCOUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size_kib       <= KB_RESET;
      kernel_end_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEM_SIZE:   mem_size_kib       <= cfg_data[KB_W-1:0];
        REG_KERNEL_END: kernel_end_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_words <= '0;
      used_count   <= '0;
      res_pending  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      active_words <= active_words_next;
      used_count   <= used_count_next;
      res_pending  <= res_pending_next;
      if (res_pending && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    reserved   <= reserved_next;
    wc         <= wc_next;
    fidx       <= fidx_next;
    word       <= word_next;
    srch       <= srch_next;
    bitidx     <= bitidx_next;
    half       <= half_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (res_pending && out_free) begin
      frame_address <= res_addr;
      status        <= res_status;
      used_frames   <= used_count;
    end
  end

  always_comb begin
    state_next        = state;
    active_words_next = active_words;
    reserved_next     = reserved;
    used_count_next   = used_count;
    wc_next           = wc;
    fidx_next         = fidx;
    word_next         = word;
    srch_next         = srch;
    bitidx_next       = bitidx;
    half_next         = half;
    res_addr_next     = res_addr;
    res_status_next   = res_status;
    res_pending_next  = res_pending;
    mem_we            = 1'b0;
    mem_wa            = wc[WORD_IDX_W-1:0];
    mem_wd            = init_val;
    mem_ra            = wc[WORD_IDX_W-1:0];
    if (res_pending && out_free) begin
      res_pending_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          res_addr_next   = '0;
          res_status_next = STAT_DONE;
          wc_next         = '0;
          case (op)
            OP_INIT: begin
              active_words_next = init_words;
              reserved_next     = init_reserved;
              used_count_next   = init_count;
              if (init_words == '0) begin
                res_pending_next = 1'b1;
              end else begin
                state_next = ST_INIT;
              end
            end
            OP_ALLOC: begin
              if (active_words == '0) begin
                res_status_next  = STAT_OOM;
                res_pending_next = 1'b1;
              end else begin
                state_next = ST_ALLOC_RD;
              end
            end
            OP_FREE: begin
              fidx_next = IDX_W'(free_frame);
              if (free_out_range) begin
                res_status_next  = STAT_IGNORED;
                res_pending_next = 1'b1;
              end else begin
                state_next = ST_FREE_RD;
              end
            end
            default: begin
              res_pending_next = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        mem_we  = 1'b1;
        wc_next = wc_inc;
        if (wc_inc == active_words) begin
          res_pending_next = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_ALLOC_RD: begin
        state_next = ST_ALLOC_CHK;
      end
      ST_ALLOC_CHK: begin
        if (mem_q == ONES) begin
          if (wc_inc == active_words) begin
            res_status_next  = STAT_OOM;
            res_pending_next = 1'b1;
            state_next       = ST_IDLE;
          end else begin
            wc_next    = wc_inc;
            state_next = ST_ALLOC_RD;
          end
        end else begin
          word_next   = mem_q;
          srch_next   = ~mem_q;
          bitidx_next = '0;
          half_next   = BIT_W'(WORD_BITS / 2);
          state_next  = ST_ALLOC_BIT;
        end
      end
      ST_ALLOC_BIT: begin
        // binary search for the lowest clear bit
        if ((srch & lo_mask) == '0) begin
          srch_next   = srch >> half;
          bitidx_next = bitidx | half;
        end
        half_next = half >> 1;
        if (half == BIT_W'(1)) begin
          state_next = ST_ALLOC_SET;
        end
      end
      ST_ALLOC_SET: begin
        mem_we        = 1'b1;
        mem_wd        = word | (ONE << bitidx);
        res_addr_next = ADDR_W'({wc[WORD_IDX_W-1:0], bitidx, {FRAME_SHIFT{1'b0}}});
        if (used_count < COUNT_W'(FRAMES)) begin
          used_count_next = used_count + COUNT_W'(1);
        end
        res_pending_next = 1'b1;
        state_next       = ST_IDLE;
      end
      ST_FREE_RD: begin
        mem_ra     = fidx[IDX_W-1:WORD_SHIFT];
        state_next = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        mem_wa = fidx[IDX_W-1:WORD_SHIFT];
        mem_wd = mem_q & ~(ONE << fidx[WORD_SHIFT-1:0]);
        if (!mem_q[fidx[WORD_SHIFT-1:0]]) begin
          res_status_next = STAT_IGNORED;
        end else begin
          mem_we = 1'b1;
          if (used_count != '0) begin
            used_count_next = used_count - COUNT_W'(1);
          end
        end
        res_pending_next = 1'b1;
        state_next       = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the bitmap frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [bfa_pkg::ADDR_W-1:0]        frame_address,
  input  logic [1:0]                        status,
  input  logic [bfa_pkg::COUNT_W-1:0]       used_frames
);
  import bfa_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_address) &&
      $stable(status) && $stable(used_frames))
    else $error("stalled result changed");

  // no address on an out-of-memory or ignored result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_DONE |-> frame_address == '0)
    else $error("address on failed item");

  // addresses are frame aligned
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_address[FRAME_SHIFT-1:0] == '0)
    else $error("unaligned frame address");

  // used count saturates
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> used_frames <= COUNT_W'(FRAMES))
    else $error("used count above frame total");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (.*);
